### hdl/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg: shared definitions for the square matrix multiply core
// Widths, defaults, sequencer states and the control word that travels
// alongside each operand pair into the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package smm_pkg;

  // Default matrix dimension (legal range 2 to 8)
  localparam int DIM_DEFAULT = 8;

  // Element and result widths
  localparam int VAL_W  = 16;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 35;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // Marks carried with each operand pair
  typedef struct packed {
    logic first;       // first term of a dot product
    logic last;        // last term of a dot product
    logic last_entry;  // last term of the last product entry
  } ctl_t;

endpackage

### hdl/smm_mac.sv
// ----------------------------------------------------------------------------
// smm_mac: shared multiply-accumulate unit
// Registers the product of one operand pair per cycle, then folds it into
// a wide exact accumulator; emits the sum when the last term arrives.
// ----------------------------------------------------------------------------
module smm_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  smm_pkg::ctl_t                     in_ctl,
  input  logic signed [smm_pkg::VAL_W-1:0]  a_op,
  input  logic signed [smm_pkg::VAL_W-1:0]  b_op,
  output logic                              out_valid,
  output logic signed [smm_pkg::ACC_W-1:0]  out_value,
  output logic                              out_last
);

  localparam int PROD_W = smm_pkg::PROD_W;
  localparam int ACC_W  = smm_pkg::ACC_W;

  logic signed [PROD_W-1:0] prod;
  logic                     p_valid;
  smm_pkg::ctl_t            p_ctl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  sum;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= in_valid;
    end
    prod  <= a_op * b_op;
    p_ctl <= in_ctl;
  end

  // Restart the sum on the first term, otherwise add on
  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign sum      = p_ctl.first ? prod_ext : acc + prod_ext;

  // Accumulate stage and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= p_valid && p_ctl.last;
    end
    if (p_valid) begin
      acc <= sum;
    end
    if (p_valid && p_ctl.last) begin
      out_value <= sum;
      out_last  <= p_ctl.last_entry;
    end
  end

endmodule

### hdl/square_matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// square_matrix_multiply_core: C = A x B for DIM by DIM signed matrices
// Loads A and B one element pair per item in row-major order, then walks
// all DIM^3 terms through one shared multiply-accumulate unit and emits
// C in row-major order, flagging the final entry.
//
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------
// item in  | start high while busy low  | a_value, b_value (16b signed)
// result   | result_valid, one cycle    | c_value (35b signed), last_of_matrix
//
// Loading items are accepted back to back. The item that completes DIM*DIM
// elements raises busy until the final result has come out: the run issues
// one multiply-accumulate per cycle to the shared unit, and each term then
// passes the store read, multiply and accumulate stages. A result appears
// as each dot product completes. Reset clears the sequencer and the load
// count; the stores keep no reset value. The receiver cannot stall.
// ----------------------------------------------------------------------------
module square_matrix_multiply_core #(
  parameter int DIM = smm_pkg::DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [smm_pkg::VAL_W-1:0]  a_value,
  input  logic signed [smm_pkg::VAL_W-1:0]  b_value,
  output logic                              busy,
  output logic                              result_valid,
  output logic signed [smm_pkg::ACC_W-1:0]  c_value,
  output logic                              last_of_matrix
);

  localparam int TOTAL  = DIM * DIM;
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int IDX_W  = $clog2(DIM);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TOTAL - 1);
  localparam logic [ADDR_W-1:0] DIM_A     = ADDR_W'(DIM);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DIM - 1);

  smm_pkg::state_t state;
  smm_pkg::state_t state_next;

  logic [ADDR_W-1:0] load_count;
  logic [IDX_W-1:0]  i_idx;
  logic [IDX_W-1:0]  j_idx;
  logic [IDX_W-1:0]  k_idx;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic              accept;
  logic              issue_final;
  smm_pkg::ctl_t     issue_ctl;

  logic signed [smm_pkg::VAL_W-1:0] a_store [TOTAL];
  logic signed [smm_pkg::VAL_W-1:0] b_store [TOTAL];
  logic signed [smm_pkg::VAL_W-1:0] rd_a;
  logic signed [smm_pkg::VAL_W-1:0] rd_b;
  logic                             s1_valid;
  smm_pkg::ctl_t                    s1_ctl;

  assign busy   = (state != smm_pkg::ST_LOAD);
  assign accept = start && !busy;

  // Decode the term being issued
  assign addr_a      = ADDR_W'(i_idx) * DIM_A + ADDR_W'(k_idx);
  assign addr_b      = ADDR_W'(k_idx) * DIM_A + ADDR_W'(j_idx);
  assign issue_final = (i_idx == LAST_IDX) && (j_idx == LAST_IDX) && (k_idx == LAST_IDX);
  assign issue_ctl   = '{first: (k_idx == '0), last: (k_idx == LAST_IDX),
                         last_entry: issue_final};

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      smm_pkg::ST_LOAD: begin
        if (accept && load_count == LAST_ADDR) state_next = smm_pkg::ST_RUN;
      end
      smm_pkg::ST_RUN: begin
        if (issue_final) state_next = smm_pkg::ST_DRAIN;
      end
      smm_pkg::ST_DRAIN: begin
        if (result_valid && last_of_matrix) state_next = smm_pkg::ST_LOAD;
      end
      default: state_next = smm_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Count loaded items; wrap after the completing one
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (accept) begin
      load_count <= (load_count == LAST_ADDR) ? '0 : load_count + 1'b1;
    end
  end

  // Advance the term counters, k fastest
  always_ff @(posedge clk) begin
    if (rst) begin
      i_idx <= '0;
      j_idx <= '0;
      k_idx <= '0;
    end else if (state == smm_pkg::ST_RUN) begin
      if (k_idx == LAST_IDX) begin
        k_idx <= '0;
        if (j_idx == LAST_IDX) begin
          j_idx <= '0;
          i_idx <= (i_idx == LAST_IDX) ? '0 : i_idx + 1'b1;
        end else begin
          j_idx <= j_idx + 1'b1;
        end
      end else begin
        k_idx <= k_idx + 1'b1;
      end
    end
  end

  // Element stores: write on load, registered read during the run
  always_ff @(posedge clk) begin
    if (accept) begin
      a_store[load_count] <= a_value;
      b_store[load_count] <= b_value;
    end
    if (state == smm_pkg::ST_RUN) begin
      rd_a <= a_store[addr_a];
      rd_b <= b_store[addr_b];
    end
    s1_ctl <= issue_ctl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (state == smm_pkg::ST_RUN);
    end
  end

  smm_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ctl    (s1_ctl),
    .a_op      (rd_a),
    .b_op      (rd_b),
    .out_valid (result_valid),
    .out_value (c_value),
    .out_last  (last_of_matrix)
  );

`ifndef SYNTHESIS
  // Results only come out while the block is computing
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result outside compute phase");

  // The completing item starts the run
  a_complete_starts_run: assert property (@(posedge clk) disable iff (rst)
    (accept && load_count == LAST_ADDR) |=> state == smm_pkg::ST_RUN)
    else $error("completing item did not start the run");

  // The final result releases the block
  a_final_releases: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_of_matrix) |=> !busy)
    else $error("block stayed busy after final result");

  // No term is in flight while loading
  a_idle_pipe: assert property (@(posedge clk) disable iff (rst)
    (state == smm_pkg::ST_LOAD) |-> !s1_valid)
    else $error("term in flight during load");
`endif

endmodule
